### src/rse_pkg.sv
// ----------------------------------------------------------------------------
// rse_pkg
// Types, constants and codes shared by the RPN stack evaluator modules.
// ----------------------------------------------------------------------------
package rse_pkg;

    localparam int STACK_DEPTH   = 16;
    localparam int FRACTION_BITS = 16;
    localparam int VAL_BITS      = 48;
    localparam int CNT_W         = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W        = $clog2(STACK_DEPTH);

    typedef logic signed [VAL_BITS-1:0] t_val;

    localparam t_val VAL_MAX = {1'b0, {(VAL_BITS-1){1'b1}}};
    localparam t_val VAL_MIN = {1'b1, {(VAL_BITS-1){1'b0}}};

    typedef enum logic [2:0] {
        OP_PUSH    = 3'd0,
        OP_ADD     = 3'd1,
        OP_SUB     = 3'd2,
        OP_MUL     = 3'd3,
        OP_DIV     = 3'd4,
        OP_END     = 3'd5,
        OP_ILLEGAL = 3'd6
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_LEFTOVER = 3'd1,
        ST_FEW      = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_ILLEGAL  = 3'd4,
        ST_OVERFLOW = 3'd5
    } t_status;

    typedef struct packed {
        logic    start;
        t_opcode op;
    } t_alu_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_Y,
        S_RD_X,
        S_EXEC,
        S_END_RD,
        S_EMIT
    } t_ctl_state;

    typedef enum logic [2:0] {
        A_IDLE,
        A_ADD,
        A_MUL,
        A_MFIN,
        A_DIV,
        A_DFIN,
        A_DONE
    } t_alu_state;

endpackage

### src/rse_stack_ram.sv
// ----------------------------------------------------------------------------
// rse_stack_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module rse_stack_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/rse_alu.sv
// ----------------------------------------------------------------------------
// rse_alu
// Saturating Q31.16 add, subtract, multiply (four 24x24 partial products)
// and restoring divide (one quotient bit per cycle).
// ----------------------------------------------------------------------------
module rse_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rse_pkg::t_alu_req i_req,
    input  rse_pkg::t_val     i_x,
    input  rse_pkg::t_val     i_y,
    output logic              o_done,
    output rse_pkg::t_val     o_result,
    output logic              o_div_zero
);

    localparam int V      = rse_pkg::VAL_BITS;
    localparam int H      = V / 2;
    localparam int DIV_W  = V + rse_pkg::FRACTION_BITS;
    localparam int DCNT_W = $clog2(DIV_W);

    rse_pkg::t_alu_state r_state, n_state;

    rse_pkg::t_opcode    r_op;
    rse_pkg::t_val       r_x, r_y, r_res;
    logic [V-1:0]        r_ma, r_mb;
    logic                r_neg, r_dz;
    logic [2*V-1:0]      r_acc;
    logic [V-1:0]        r_pp;
    logic [1:0]          r_sh;
    logic [2:0]          r_step;
    logic [V:0]          r_rem;
    logic [DIV_W-1:0]    r_quo, r_dvd;
    logic [DCNT_W-1:0]   r_cnt;

    logic [V-1:0]        ma_in, mb_in;
    logic signed [V:0]   sum;
    logic [H-1:0]        pa, pb;
    logic [V:0]          trial;
    logic                qbit;
    logic [2*V-1:0]      mshift;

    function automatic rse_pkg::t_val sat_mag(input logic [V-1:0] m, input logic neg,
                                              input logic big);
        rse_pkg::t_val res;
        if (neg) begin
            res = (big || m[V-1]) ? rse_pkg::VAL_MIN : -$signed(m);
        end else begin
            res = (big || m[V-1]) ? rse_pkg::VAL_MAX : $signed(m);
        end
        return res;
    endfunction

    assign ma_in = i_x[V-1] ? V'(-i_x) : V'(i_x);
    assign mb_in = i_y[V-1] ? V'(-i_y) : V'(i_y);

    always_comb begin
        if (r_op == rse_pkg::OP_SUB) begin
            sum = {r_x[V-1], r_x} - {r_y[V-1], r_y};
        end else begin
            sum = {r_x[V-1], r_x} + {r_y[V-1], r_y};
        end
        pa     = r_step[0] ? r_ma[V-1:H] : r_ma[H-1:0];
        pb     = r_step[1] ? r_mb[V-1:H] : r_mb[H-1:0];
        trial  = {r_rem[V-1:0], r_dvd[DIV_W-1]};
        qbit   = (trial >= {1'b0, r_mb});
        mshift = r_acc >> rse_pkg::FRACTION_BITS;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rse_pkg::A_IDLE: begin
                if (i_req.start) begin
                    unique case (i_req.op)
                        rse_pkg::OP_MUL: n_state = rse_pkg::A_MUL;
                        rse_pkg::OP_DIV: n_state = (i_y == '0) ? rse_pkg::A_DONE
                                                               : rse_pkg::A_DIV;
                        default:         n_state = rse_pkg::A_ADD;
                    endcase
                end
            end
            rse_pkg::A_ADD:  n_state = rse_pkg::A_DONE;
            rse_pkg::A_MUL:  n_state = (r_step == 3'd4) ? rse_pkg::A_MFIN : rse_pkg::A_MUL;
            rse_pkg::A_MFIN: n_state = rse_pkg::A_DONE;
            rse_pkg::A_DIV:  n_state = (r_cnt == '0) ? rse_pkg::A_DFIN : rse_pkg::A_DIV;
            rse_pkg::A_DFIN: n_state = rse_pkg::A_DONE;
            rse_pkg::A_DONE: n_state = rse_pkg::A_IDLE;
            default:         n_state = rse_pkg::A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rse_pkg::A_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            rse_pkg::A_IDLE: begin
                r_op   <= i_req.op;
                r_x    <= i_x;
                r_y    <= i_y;
                r_ma   <= ma_in;
                r_mb   <= mb_in;
                r_neg  <= i_x[V-1] ^ i_y[V-1];
                r_acc  <= '0;
                r_step <= '0;
                r_rem  <= '0;
                r_quo  <= '0;
                r_dvd  <= DIV_W'({ma_in, {rse_pkg::FRACTION_BITS{1'b0}}});
                r_cnt  <= DCNT_W'(DIV_W - 1);
                r_dz   <= (i_req.op == rse_pkg::OP_DIV) && (i_y == '0);
                r_res  <= '0;
            end
            rse_pkg::A_ADD: begin
                if (sum[V] != sum[V-1]) begin
                    r_res <= sum[V] ? rse_pkg::VAL_MIN : rse_pkg::VAL_MAX;
                end else begin
                    r_res <= sum[V-1:0];
                end
            end
            rse_pkg::A_MUL: begin
                // Product of step k is registered in r_pp and added at the next step,
                // shifted by its half-word weight.
                if (r_step != 3'd0) begin
                    r_acc <= r_acc + ((2*V)'(r_pp) << (H * r_sh));
                end
                r_pp   <= V'(pa * pb);
                r_sh   <= 2'(r_step[0]) + 2'(r_step[1]);
                r_step <= r_step + 3'd1;
            end
            rse_pkg::A_MFIN: begin
                r_res <= sat_mag(mshift[V-1:0], r_neg, (mshift >> V) != '0);
            end
            rse_pkg::A_DIV: begin
                r_rem <= qbit ? (trial - {1'b0, r_mb}) : trial;
                r_quo <= {r_quo[DIV_W-2:0], qbit};
                r_dvd <= {r_dvd[DIV_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
            end
            rse_pkg::A_DFIN: begin
                r_res <= sat_mag(r_quo[V-1:0], r_neg, (r_quo >> V) != '0);
            end
            default: begin
            end
        endcase
    end

    assign o_done     = (r_state == rse_pkg::A_DONE);
    assign o_result   = r_res;
    assign o_div_zero = r_dz;

endmodule

### src/rpn_stack_evaluator.sv
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// Postfix expression evaluator over a stack RAM of signed Q31.16 values.
// ----------------------------------------------------------------------------
// One token is taken per input beat and processed to completion before the
// next is taken. A push that fits, or a token dropped after an error, stays
// idle. An operator reads its two operands from the stack RAM in S_RD_Y and
// S_RD_X, then waits on the arithmetic unit: add and subtract via A_ADD,
// multiply over four 24x24 partial products, divide at one quotient bit per
// cycle over VAL_BITS + FRACTION_BITS bits. An end token reaches the output
// register via S_END_RD and S_EMIT, or S_EMIT alone on an empty stack, but
// not after an error. A result waiting in the output register holds off the
// next token only if that token itself has a result to deliver.
module rpn_stack_evaluator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [2:0]                     i_opcode,
    input  logic signed [rse_pkg::VAL_BITS-1:0] i_operand_value,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [rse_pkg::VAL_BITS-1:0] o_result_value,
    output logic [2:0]                     o_status,
    output logic                           o_divide_by_zero_seen
);

    localparam int CW = rse_pkg::CNT_W;
    localparam int AW = rse_pkg::ADDR_W;

    rse_pkg::t_ctl_state r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic                r_abort, n_abort;
    logic                r_dz, n_dz;
    rse_pkg::t_opcode    r_op, n_op;
    rse_pkg::t_val       r_y, n_y;
    rse_pkg::t_val       r_pv, n_pv;
    rse_pkg::t_status    r_ps, n_ps;
    logic                r_pdz, n_pdz;
    logic                r_ov, n_ov;
    rse_pkg::t_val       r_oval, n_oval;
    rse_pkg::t_status    r_ost, n_ost;
    logic                r_odz, n_odz;

    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    rse_pkg::t_val       ram_wdata, ram_rdata;
    logic [CW-1:0]       cm1, cm2;
    logic                accept, load;

    rse_pkg::t_alu_req   alu_req;
    logic                alu_done, alu_dz;
    rse_pkg::t_val       alu_res;

    rse_stack_ram #(
        .WIDTH (rse_pkg::VAL_BITS),
        .DEPTH (rse_pkg::STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rse_alu u_alu (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (alu_req),
        .i_x        (ram_rdata),
        .i_y        (r_y),
        .o_done     (alu_done),
        .o_result   (alu_res),
        .o_div_zero (alu_dz)
    );

    assign cm1    = r_count - 1'b1;
    assign cm2    = r_count - 2'd2;
    assign accept = (r_state == rse_pkg::S_IDLE) && i_in_valid;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_abort = r_abort;
        n_dz    = r_dz;
        n_op    = r_op;
        n_y     = r_y;
        n_pv    = r_pv;
        n_ps    = r_ps;
        n_pdz   = r_pdz;
        ram_we    = 1'b0;
        ram_waddr = cm2[AW-1:0];
        ram_wdata = alu_res;
        ram_re    = 1'b0;
        ram_raddr = cm1[AW-1:0];
        alu_req.start = 1'b0;
        alu_req.op    = r_op;
        load       = 1'b0;
        o_in_stall = (r_state != rse_pkg::S_IDLE);

        unique case (r_state)
            rse_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_op  = rse_pkg::t_opcode'(i_opcode);
                    n_pv  = '0;
                    n_pdz = r_dz;
                    if (i_opcode == rse_pkg::OP_END) begin
                        if (r_abort || r_count == '0) begin
                            if (!r_abort) begin
                                n_ps    = rse_pkg::ST_EMPTY;
                                n_state = rse_pkg::S_EMIT;
                            end
                            n_count = '0;
                            n_abort = 1'b0;
                            n_dz    = 1'b0;
                        end else begin
                            ram_re  = 1'b1;
                            n_state = rse_pkg::S_END_RD;
                        end
                    end else if (!r_abort) begin
                        priority if (i_opcode == rse_pkg::OP_PUSH) begin
                            if (r_count == CW'(rse_pkg::STACK_DEPTH)) begin
                                n_ps    = rse_pkg::ST_OVERFLOW;
                                n_abort = 1'b1;
                                n_state = rse_pkg::S_EMIT;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[AW-1:0];
                                ram_wdata = i_operand_value;
                                n_count   = r_count + 1'b1;
                            end
                        end else if (i_opcode == rse_pkg::OP_ADD ||
                                     i_opcode == rse_pkg::OP_SUB ||
                                     i_opcode == rse_pkg::OP_MUL ||
                                     i_opcode == rse_pkg::OP_DIV) begin
                            if (r_count < CW'(2)) begin
                                n_ps    = rse_pkg::ST_FEW;
                                n_abort = 1'b1;
                                n_state = rse_pkg::S_EMIT;
                            end else begin
                                ram_re  = 1'b1;
                                n_state = rse_pkg::S_RD_Y;
                            end
                        end else begin
                            n_ps    = rse_pkg::ST_ILLEGAL;
                            n_abort = 1'b1;
                            n_state = rse_pkg::S_EMIT;
                        end
                    end
                end
            end
            rse_pkg::S_RD_Y: begin
                n_y       = ram_rdata;
                ram_re    = 1'b1;
                ram_raddr = cm2[AW-1:0];
                n_state   = rse_pkg::S_RD_X;
            end
            rse_pkg::S_RD_X: begin
                alu_req.start = 1'b1;
                n_state       = rse_pkg::S_EXEC;
            end
            rse_pkg::S_EXEC: begin
                if (alu_done) begin
                    ram_we  = 1'b1;
                    n_count = cm1;
                    n_dz    = r_dz | alu_dz;
                    n_state = rse_pkg::S_IDLE;
                end
            end
            rse_pkg::S_END_RD: begin
                n_pv    = ram_rdata;
                n_ps    = (r_count > CW'(1)) ? rse_pkg::ST_LEFTOVER : rse_pkg::ST_OK;
                n_count = '0;
                n_abort = 1'b0;
                n_dz    = 1'b0;
                n_state = rse_pkg::S_EMIT;
            end
            rse_pkg::S_EMIT: begin
                if (!r_ov || !i_out_stall) begin
                    load    = 1'b1;
                    n_state = rse_pkg::S_IDLE;
                end
            end
            default: n_state = rse_pkg::S_IDLE;
        endcase

        n_ov   = (r_ov && i_out_stall) || load;
        n_oval = load ? r_pv  : r_oval;
        n_ost  = load ? r_ps  : r_ost;
        n_odz  = load ? r_pdz : r_odz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rse_pkg::S_IDLE;
            r_count <= '0;
            r_abort <= 1'b0;
            r_dz    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_abort <= n_abort;
            r_dz    <= n_dz;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_y    <= n_y;
        r_pv   <= n_pv;
        r_ps   <= n_ps;
        r_pdz  <= n_pdz;
        r_oval <= n_oval;
        r_ost  <= n_ost;
        r_odz  <= n_odz;
    end

    assign o_out_valid           = r_ov;
    assign o_result_value        = r_oval;
    assign o_status              = r_ost;
    assign o_divide_by_zero_seen = r_odz;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(rse_pkg::STACK_DEPTH))
        else $error("stack count above depth");

    a_exec_operands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rse_pkg::S_EXEC) |-> (r_count >= CW'(2)))
        else $error("operator executing with fewer than two operands");

    a_drop_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_abort && i_opcode != rse_pkg::OP_END)
            |=> (r_state == rse_pkg::S_IDLE) && $stable(r_count))
        else $error("token after error was not dropped");

endmodule
